### design/cpra_pkg.sv
// Shared constants, codes and types of the contiguous page run allocator.
// No dependencies; used by every module of the block.
package cpra_pkg;

  localparam int unsigned PAGE_TOTAL = 256;
  localparam int unsigned PAGE_W     = $clog2(PAGE_TOTAL);
  localparam int unsigned CNT_W      = PAGE_W + 1;
  localparam int unsigned START_W    = 8;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned SUM_W      = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned PAGE_OUT_W = 8;

  typedef logic [1:0] mark_t;

  localparam mark_t MARK_FREE     = 2'd0;
  localparam mark_t MARK_ALLOC    = 2'd1;
  localparam mark_t MARK_RESERVED = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE         = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE_RESERVED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE_FREE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ZERO_COUNT    = 3'd5;

  // Controls from the sequencer to the mark ring.
  typedef struct packed {
    logic  shift;
    mark_t tail_mark;
  } ring_ctl_t;

  // Power-up pattern: pages 0-2 and 7-15 reserved.
  function automatic mark_t reset_mark(input int unsigned idx);
    mark_t m;
    m = MARK_FREE;
    if ((idx <= 2) || ((idx >= 7) && (idx <= 15))) begin
      m = MARK_RESERVED;
    end
    return m;
  endfunction

endpackage

### design/cpra_cell.sv
// One page mark cell of the rotating mark ring.
// Depends on cpra_pkg.
module cpra_cell
  import cpra_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  mark_t rst_mark_i,  // tied to a constant per position
  input  logic  shift_i,
  input  mark_t mark_i,
  output mark_t mark_o
);

  mark_t mark_q;
  mark_t mark_d;

  assign mark_d = shift_i ? mark_i : mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= rst_mark_i;
    end else begin
      mark_q <= mark_d;
    end
  end

  assign mark_o = mark_q;

endmodule

### design/cpra_ring.sv
// Ring of page mark cells; marks move one cell toward the head per shift.
// Depends on cpra_pkg and cpra_cell.
module cpra_ring
  import cpra_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ring_ctl_t ctl_i,
  output mark_t     head_mark_o
);

  mark_t marks [PAGE_TOTAL];

  for (genvar k = 0; k < PAGE_TOTAL; k++) begin : g_cell
    mark_t nxt;
    if (k == PAGE_TOTAL - 1) begin : g_tail
      assign nxt = ctl_i.tail_mark;
    end else begin : g_mid
      assign nxt = marks[k+1];
    end

    cpra_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rst_mark_i(reset_mark(k)),
      .shift_i   (ctl_i.shift),
      .mark_i    (nxt),
      .mark_o    (marks[k])
    );
  end

  assign head_mark_o = marks[0];

endmodule

### design/cpra_ctrl.sv
// Sequencer: accepts items, walks the ring one page per cycle, holds result.
// Depends on cpra_pkg.
module cpra_ctrl
  import cpra_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_func_i,
  input  logic [START_W-1:0]    in_start_i,
  input  logic [COUNT_W-1:0]    in_count_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic [PAGE_OUT_W-1:0] out_first_o,
  output logic [PAGE_OUT_W-1:0] out_fault_o,
  input  mark_t                 head_mark_i,
  output ring_ctl_t             ring_ctl_o
);

  localparam logic [2:0] STATE_IDLE   = 3'd0;
  localparam logic [2:0] STATE_ALLOC1 = 3'd1;
  localparam logic [2:0] STATE_ALLOC2 = 3'd2;
  localparam logic [2:0] STATE_FREE   = 3'd3;
  localparam logic [2:0] STATE_DONE   = 3'd4;

  logic [2:0]            state_q, state_d;
  logic                  func_q, func_d;
  logic [START_W-1:0]    start_q, start_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [PAGE_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]      run_q, run_d;
  logic                  found_q, found_d;
  logic [PAGE_W-1:0]     fstart_q, fstart_d;
  logic                  stop_q, stop_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [PAGE_OUT_W-1:0] first_q, first_d;
  logic [PAGE_OUT_W-1:0] fault_q, fault_d;
  logic                  ovalid_q, ovalid_d;
  logic [STATUS_W-1:0]   ostatus_q;
  logic [PAGE_OUT_W-1:0] ofirst_q, ofault_q;
  logic                  out_load;

  logic [SUM_W-1:0] cx, lo, hi, fsum;
  logic [CNT_W-1:0] run_nx;
  logic             in_run, last, page_free;

  assign cx        = SUM_W'(cnt_q);
  assign lo        = (func_q == FUNC_FREE) ? SUM_W'(start_q) : SUM_W'(fstart_q);
  assign hi        = lo + SUM_W'(count_q);
  assign in_run    = (cx >= lo) && (cx < hi);
  assign last      = (cnt_q == PAGE_W'(PAGE_TOTAL - 1));
  assign page_free = (head_mark_i == MARK_FREE);
  assign run_nx    = page_free ? (run_q + CNT_W'(1)) : '0;
  // start of a run that ends on the current page
  assign fsum      = cx + SUM_W'(1) - SUM_W'(count_q);

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    start_d  = start_q;
    count_d  = count_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    found_d  = found_q;
    fstart_d = fstart_q;
    stop_d   = stop_q;
    status_d = status_q;
    first_d  = first_q;
    fault_d  = fault_q;
    out_load = 1'b0;
    ring_ctl_o.shift     = 1'b0;
    ring_ctl_o.tail_mark = head_mark_i;

    unique case (state_q)
      STATE_IDLE: begin
        if (in_valid_i) begin
          func_d   = in_func_i;
          start_d  = in_start_i;
          count_d  = in_count_i;
          cnt_d    = '0;
          run_d    = '0;
          found_d  = 1'b0;
          stop_d   = 1'b0;
          status_d = ST_OK;
          first_d  = '0;
          fault_d  = '0;
          if (in_func_i == FUNC_FREE) begin
            if ((SUM_W'(in_start_i) + SUM_W'(in_count_i)) > SUM_W'(PAGE_TOTAL)) begin
              status_d = ST_RANGE;
              state_d  = STATE_DONE;
            end else begin
              state_d = STATE_FREE;
            end
          end else if (in_count_i == '0) begin
            status_d = ST_ZERO_COUNT;
            state_d  = STATE_DONE;
          end else if (SUM_W'(in_count_i) > SUM_W'(PAGE_TOTAL)) begin
            status_d = ST_NO_SPACE;
            state_d  = STATE_DONE;
          end else begin
            state_d = STATE_ALLOC1;
          end
        end
      end
      STATE_ALLOC1: begin
        // search pass: ring rotates unchanged
        ring_ctl_o.shift = 1'b1;
        cnt_d = last ? '0 : (cnt_q + PAGE_W'(1));
        run_d = run_nx;
        if (!found_q && page_free && (SUM_W'(run_nx) == SUM_W'(count_q))) begin
          found_d  = 1'b1;
          fstart_d = fsum[PAGE_W-1:0];
          first_d  = fsum[PAGE_OUT_W-1:0];
        end
        if (last) begin
          if (found_d) begin
            state_d = STATE_ALLOC2;
          end else begin
            status_d = ST_NO_SPACE;
            state_d  = STATE_DONE;
          end
        end
      end
      STATE_ALLOC2: begin
        // marking pass
        ring_ctl_o.shift = 1'b1;
        cnt_d = last ? '0 : (cnt_q + PAGE_W'(1));
        if (in_run) begin
          ring_ctl_o.tail_mark = MARK_ALLOC;
        end
        if (last) begin
          state_d = STATE_DONE;
        end
      end
      STATE_FREE: begin
        ring_ctl_o.shift = 1'b1;
        cnt_d = last ? '0 : (cnt_q + PAGE_W'(1));
        if (in_run && !stop_q) begin
          if (head_mark_i == MARK_RESERVED) begin
            status_d = ST_FREE_RESERVED;
            fault_d  = cx[PAGE_OUT_W-1:0];
            stop_d   = 1'b1;
          end else if (page_free) begin
            status_d = ST_FREE_FREE;
            fault_d  = cx[PAGE_OUT_W-1:0];
            stop_d   = 1'b1;
          end else begin
            ring_ctl_o.tail_mark = MARK_FREE;
          end
        end
        if (last) begin
          state_d = STATE_DONE;
        end
      end
      STATE_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = STATE_IDLE;
        end
      end
      default: begin
        state_d = STATE_IDLE;
      end
    endcase
  end

  assign ovalid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= STATE_IDLE;
      ovalid_q <= 1'b0;
      found_q  <= 1'b0;
      stop_q   <= 1'b0;
      cnt_q    <= '0;
      run_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      found_q  <= found_d;
      stop_q   <= stop_d;
      cnt_q    <= cnt_d;
      run_q    <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    start_q  <= start_d;
    count_q  <= count_d;
    fstart_q <= fstart_d;
    status_q <= status_d;
    first_q  <= first_d;
    fault_q  <= fault_d;
    if (out_load) begin
      ostatus_q <= status_q;
      ofirst_q  <= first_q;
      ofault_q  <= fault_q;
    end
  end

  assign in_ready_o   = (state_q == STATE_IDLE);
  assign out_valid_o  = ovalid_q;
  assign out_status_o = ostatus_q;
  assign out_first_o  = ofirst_q;
  assign out_fault_o  = ofault_q;

endmodule

### design/contiguous_page_run_allocator.sv
// Top level of the first-fit contiguous page run allocator.
// Depends on cpra_pkg, cpra_ctrl, cpra_ring (and cpra_cell below it).
//
//  Channel  Dir  Signals                  Contents
//  s_axis   in   tvalid/tready/tdata/tuser one request transaction
//  m_axis   out  tvalid/tready/tdata       one result transaction per request
//
// Allocate: the request is taken in the idle state, then a full search rotation
// of the mark ring, a full marking rotation and the load of the output
// register follow. An allocate that finds no run skips the marking rotation.
// A free makes one full rotation before the output load.
// Rejected requests (zero count, oversize, range) skip the rotations.
// The ring shifts one page per cycle during each rotation.
// Reset loads the reserved pattern into the ring at once.
// A held result does not block the next request; only a second finished
// result waits for the output register to drain.
module contiguous_page_run_allocator
  import cpra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] start_page, [16:8] page_count, zero pad
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [2:0] status, [10:3] first_page,
                                        // [18:11] fault_page, zero pad
);

  ring_ctl_t             ring_ctl;
  mark_t                 head_mark;
  logic [STATUS_W-1:0]   status;
  logic [PAGE_OUT_W-1:0] first_page;
  logic [PAGE_OUT_W-1:0] fault_page;

  cpra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (s_axis_tuser_i),
    .in_start_i  (s_axis_tdata_i[START_W-1:0]),
    .in_count_i  (s_axis_tdata_i[START_W+COUNT_W-1:START_W]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_status_o(status),
    .out_first_o (first_page),
    .out_fault_o (fault_page),
    .head_mark_i (head_mark),
    .ring_ctl_o  (ring_ctl)
  );

  cpra_ring u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ring_ctl),
    .head_mark_o(head_mark)
  );

  assign m_axis_tdata_o = {5'b0, fault_page, first_page, status};

endmodule
